[rtl/ceag_pkg.sv]
// ----------------------------------------------------------------------------
// ceag_pkg
// Shared types and mode codes for the effective address generator.
// ----------------------------------------------------------------------------
package ceag_pkg;

   localparam int unsigned AddrWidth = 24;
   localparam int unsigned RegWidth  = 16;
   localparam int unsigned BankWidth = 8;
   localparam int unsigned ModeWidth = 5;

   localparam logic [ModeWidth-1:0] MODE_DP        = 5'd0;
   localparam logic [ModeWidth-1:0] MODE_DPX       = 5'd1;
   localparam logic [ModeWidth-1:0] MODE_DPY       = 5'd2;
   localparam logic [ModeWidth-1:0] MODE_IDP       = 5'd3;
   localparam logic [ModeWidth-1:0] MODE_IDPX      = 5'd4;
   localparam logic [ModeWidth-1:0] MODE_IDPY      = 5'd5;
   localparam logic [ModeWidth-1:0] MODE_ILDP      = 5'd6;
   localparam logic [ModeWidth-1:0] MODE_ILDPY     = 5'd7;
   localparam logic [ModeWidth-1:0] MODE_ADDR      = 5'd8;
   localparam logic [ModeWidth-1:0] MODE_ADDR_PC   = 5'd9;
   localparam logic [ModeWidth-1:0] MODE_ADDRX     = 5'd10;
   localparam logic [ModeWidth-1:0] MODE_ADDRY     = 5'd11;
   localparam logic [ModeWidth-1:0] MODE_IADDRX    = 5'd12;
   localparam logic [ModeWidth-1:0] MODE_ILADDR    = 5'd13;
   localparam logic [ModeWidth-1:0] MODE_IADDR_PC  = 5'd14;
   localparam logic [ModeWidth-1:0] MODE_IADDRX_PC = 5'd15;
   localparam logic [ModeWidth-1:0] MODE_ILADDR_PC = 5'd16;
   localparam logic [ModeWidth-1:0] MODE_LONG      = 5'd17;
   localparam logic [ModeWidth-1:0] MODE_LONGX     = 5'd18;
   localparam logic [ModeWidth-1:0] MODE_SR        = 5'd19;
   localparam logic [ModeWidth-1:0] MODE_ISRY      = 5'd20;

   localparam logic [1:0] PTR_NONE = 2'd0;
   localparam logic [1:0] PTR_WORD = 2'd1;
   localparam logic [1:0] PTR_LONG = 2'd2;

   typedef struct packed {
      logic                 phase;
      logic [ModeWidth-1:0] mode;
      logic [AddrWidth-1:0] operand;
      logic [AddrWidth-1:0] fetched_pointer;
      logic [RegWidth-1:0]  direct_page;
      logic [RegWidth-1:0]  index_x;
      logic [RegWidth-1:0]  index_y;
      logic [RegWidth-1:0]  stack_pointer;
      logic [BankWidth-1:0] data_bank;
      logic [BankWidth-1:0] program_bank;
   } req_type;

   typedef struct packed {
      logic [AddrWidth-1:0] address;
      logic                 bank_crossed;
      logic [1:0]           pointer_size;
      logic                 mode_error;
   } rsp_type;

endpackage

[rtl/ceag_calc.sv]
// ----------------------------------------------------------------------------
// ceag_calc
// Address arithmetic for one word: base address, pointer finish, bank cross.
// ----------------------------------------------------------------------------
module ceag_calc (
   input  ceag_pkg::req_type req,
   input  logic              crossed,
   output ceag_pkg::rsp_type rsp
);
   import ceag_pkg::*;

   logic [7:0]           lo;
   logic [RegWidth-1:0]  dp_sum;
   logic [RegWidth-1:0]  dpx_sum;
   logic [RegWidth-1:0]  dpy_sum;
   logic [RegWidth-1:0]  sp_sum;
   logic [RegWidth-1:0]  opx_sum;
   logic [AddrWidth-1:0] longx_sum;
   logic [AddrWidth-1:0] ptry_sum;
   logic [AddrWidth-1:0] isry_sum;
   logic [RegWidth-1:0]  idx_low;
   logic [RegWidth-1:0]  idx_val;
   logic [AddrWidth:0]   idx_sum;
   logic                 idx_cross;
   logic                 idx_update;
   logic [AddrWidth-1:0] addr;
   logic [1:0]           psize;
   logic                 err;

   always_comb begin
      lo        = req.operand[7:0];
      dp_sum    = req.direct_page + {8'd0, lo};
      dpx_sum   = req.direct_page + req.index_x + {8'd0, lo};
      dpy_sum   = req.direct_page + req.index_y + {8'd0, lo};
      sp_sum    = req.stack_pointer + {8'd0, lo};
      opx_sum   = req.operand[RegWidth-1:0] + req.index_x;
      longx_sum = req.operand + {8'd0, req.index_x};
      ptry_sum  = req.fetched_pointer + {8'd0, req.index_y};
      isry_sum  = {req.data_bank, req.fetched_pointer[RegWidth-1:0]}
                  + {8'd0, req.index_y};

      idx_low   = req.phase ? req.fetched_pointer[RegWidth-1:0]
                            : req.operand[RegWidth-1:0];
      idx_val   = (req.phase || (req.mode == MODE_ADDRY)) ? req.index_y : req.index_x;
      idx_sum   = {1'b0, req.data_bank, 16'd0} + {9'd0, idx_low} + {9'd0, idx_val};
      idx_cross = idx_sum[AddrWidth:RegWidth] != {1'b0, req.data_bank};
   end

   always_comb begin
      addr       = req.operand;
      psize      = PTR_NONE;
      err        = 1'b0;
      idx_update = 1'b0;
      if (!req.phase) begin
         unique case (req.mode)
            MODE_DP:  addr = {8'd0, dp_sum};
            MODE_DPX: addr = {8'd0, dpx_sum};
            MODE_DPY: addr = {8'd0, dpy_sum};
            MODE_IDP, MODE_IDPY: begin
               addr  = {8'd0, dp_sum};
               psize = PTR_WORD;
            end
            MODE_IDPX: begin
               addr  = {8'd0, dpx_sum};
               psize = PTR_WORD;
            end
            MODE_ILDP, MODE_ILDPY: begin
               addr  = {8'd0, dp_sum};
               psize = PTR_LONG;
            end
            MODE_ADDR: addr = {req.data_bank, req.operand[RegWidth-1:0]};
            MODE_ADDR_PC, MODE_IADDR_PC:
               addr = {req.program_bank, req.operand[RegWidth-1:0]};
            MODE_ADDRX, MODE_ADDRY: begin
               addr       = idx_sum[AddrWidth-1:0];
               idx_update = 1'b1;
            end
            MODE_IADDRX: begin
               addr  = {8'd0, opx_sum};
               psize = PTR_WORD;
            end
            MODE_ILADDR: begin
               addr  = {8'd0, req.operand[RegWidth-1:0]};
               psize = PTR_LONG;
            end
            MODE_IADDRX_PC: addr = {req.program_bank, opx_sum};
            MODE_LONGX:     addr = longx_sum;
            MODE_SR:        addr = {8'd0, sp_sum};
            MODE_ISRY: begin
               addr  = {8'd0, sp_sum};
               psize = PTR_WORD;
            end
            default: addr = req.operand;
         endcase
      end else begin
         unique case (req.mode)
            MODE_IDP, MODE_IDPX:
               addr = {req.data_bank, req.fetched_pointer[RegWidth-1:0]};
            MODE_IDPY: begin
               addr       = idx_sum[AddrWidth-1:0];
               idx_update = 1'b1;
            end
            MODE_ILDP, MODE_ILADDR: addr = req.fetched_pointer;
            MODE_ILDPY:  addr = ptry_sum;
            MODE_IADDRX: addr = {req.program_bank, req.fetched_pointer[RegWidth-1:0]};
            MODE_ISRY:   addr = isry_sum;
            default: begin
               addr = req.operand;
               err  = 1'b1;
            end
         endcase
      end
   end

   assign rsp.address      = addr;
   assign rsp.bank_crossed = idx_update ? idx_cross : crossed;
   assign rsp.pointer_size = psize;
   assign rsp.mode_error   = err;

endmodule

[rtl/cpu_effective_address_generator.sv]
// ----------------------------------------------------------------------------
// cpu_effective_address_generator
// Two-phase effective address generation for all 21 addressing modes.
// Path: a request goes into the input register, then its address into the
// result register. Throughput: one word per cycle while rsp_stall is low,
// set by the input and result registers.
// Reset: synchronous; clears both valid stages and the bank-crossed flag.
// ----------------------------------------------------------------------------
module cpu_effective_address_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_phase,
   input  logic [ceag_pkg::ModeWidth-1:0]     req_mode,
   input  logic [ceag_pkg::AddrWidth-1:0]     req_operand,
   input  logic [ceag_pkg::AddrWidth-1:0]     req_fetched_pointer,
   input  logic [ceag_pkg::RegWidth-1:0]      req_direct_page,
   input  logic [ceag_pkg::RegWidth-1:0]      req_index_x,
   input  logic [ceag_pkg::RegWidth-1:0]      req_index_y,
   input  logic [ceag_pkg::RegWidth-1:0]      req_stack_pointer,
   input  logic [ceag_pkg::BankWidth-1:0]     req_data_bank,
   input  logic [ceag_pkg::BankWidth-1:0]     req_program_bank,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ceag_pkg::AddrWidth-1:0]     rsp_address,
   output logic                               rsp_bank_crossed,
   output logic [1:0]                         rsp_pointer_size,
   output logic                               rsp_mode_error
);
   import ceag_pkg::*;

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   req_type req_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type calc_rsp;
   logic    crossed_ff;
   logic    crossed_in;
   logic    rsp_load;
   logic    req_load;

   assign rsp_load = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_load = !req_valid_ff || rsp_load;
   assign req_stall = !req_load;

   always_comb begin
      req_in.phase           = req_phase;
      req_in.mode            = req_mode;
      req_in.operand         = req_operand;
      req_in.fetched_pointer = req_fetched_pointer;
      req_in.direct_page     = req_direct_page;
      req_in.index_x         = req_index_x;
      req_in.index_y         = req_index_y;
      req_in.stack_pointer   = req_stack_pointer;
      req_in.data_bank       = req_data_bank;
      req_in.program_bank    = req_program_bank;

      req_valid_in = req_load ? req_valid : req_valid_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      crossed_in   = rsp_load ? calc_rsp.bank_crossed : crossed_ff;
   end

   ceag_calc u_calc (
      .req     (req_ff),
      .crossed (crossed_ff),
      .rsp     (calc_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crossed_ff   <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crossed_ff   <= crossed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         req_ff <= req_in;
      end
      if (rsp_load) begin
         rsp_ff <= calc_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address      = rsp_ff.address;
   assign rsp_bank_crossed = rsp_ff.bank_crossed;
   assign rsp_pointer_size = rsp_ff.pointer_size;
   assign rsp_mode_error   = rsp_ff.mode_error;

endmodule
